@@ rtl/plex_pkg.sv @@
`default_nettype none
package plex_pkg;

	localparam int KeywordCharsDefault = 8;
	localparam int LineWidthDefault    = 20;
	localparam int KindW               = 6;
	localparam int LineOutW            = 20;

	typedef enum logic [3:0] {
		S_START, S_COMMENT, S_COLON, S_LESS, S_MORE, S_IDENT, S_INT,
		S_RPOINT, S_REAL, S_ESIGN, S_ENUM, S_EXP, S_STR, S_QUOTE,
		S_HASH, S_ESCNUM
	} scan_state_t;

	localparam logic [KindW-1:0] K_ATTR    = 6'd0;
	localparam logic [KindW-1:0] K_IDENT   = 6'd1;
	localparam logic [KindW-1:0] K_KW0     = 6'd2;
	localparam logic [KindW-1:0] K_INT     = 6'd24;
	localparam logic [KindW-1:0] K_REALN   = 6'd25;
	localparam logic [KindW-1:0] K_STRLIT  = 6'd26;
	localparam logic [KindW-1:0] K_POINT   = 6'd27;
	localparam logic [KindW-1:0] K_SEMI    = 6'd28;
	localparam logic [KindW-1:0] K_LBR     = 6'd29;
	localparam logic [KindW-1:0] K_RBR     = 6'd30;
	localparam logic [KindW-1:0] K_RBRACE  = 6'd31;
	localparam logic [KindW-1:0] K_PLUS    = 6'd32;
	localparam logic [KindW-1:0] K_MINUS   = 6'd33;
	localparam logic [KindW-1:0] K_MUL     = 6'd34;
	localparam logic [KindW-1:0] K_DIV     = 6'd35;
	localparam logic [KindW-1:0] K_EQ      = 6'd36;
	localparam logic [KindW-1:0] K_COMMA   = 6'd37;
	localparam logic [KindW-1:0] K_ASSIGN  = 6'd38;
	localparam logic [KindW-1:0] K_COLON   = 6'd39;
	localparam logic [KindW-1:0] K_LE      = 6'd40;
	localparam logic [KindW-1:0] K_NE      = 6'd41;
	localparam logic [KindW-1:0] K_LT      = 6'd42;
	localparam logic [KindW-1:0] K_GE      = 6'd43;
	localparam logic [KindW-1:0] K_GT      = 6'd44;
	localparam logic [KindW-1:0] K_ERROR   = 6'd45;
	localparam logic [KindW-1:0] K_EOF     = 6'd46;

	localparam int NumKw = 22;

	// Keyword text, eight characters, left aligned, zero padded.
	function automatic logic [63:0] kw_text(input logic [4:0] i);
		case (i)
			5'd0:  kw_text = {"BEGIN", 24'h0};
			5'd1:  kw_text = {"BOOLEAN", 8'h0};
			5'd2:  kw_text = {"COPY", 32'h0};
			5'd3:  kw_text = {"DO", 48'h0};
			5'd4:  kw_text = {"ELSE", 32'h0};
			5'd5:  kw_text = {"END", 40'h0};
			5'd6:  kw_text = {"FALSE", 24'h0};
			5'd7:  kw_text = {"FIND", 32'h0};
			5'd8:  kw_text = {"FORWARD", 8'h0};
			5'd9:  kw_text = "FUNCTION";
			5'd10: kw_text = {"IF", 48'h0};
			5'd11: kw_text = {"INTEGER", 8'h0};
			5'd12: kw_text = {"LENGTH", 16'h0};
			5'd13: kw_text = {"READLN", 16'h0};
			5'd14: kw_text = {"REAL", 32'h0};
			5'd15: kw_text = {"SORT", 32'h0};
			5'd16: kw_text = {"STRING", 16'h0};
			5'd17: kw_text = {"THEN", 32'h0};
			5'd18: kw_text = {"TRUE", 32'h0};
			5'd19: kw_text = {"VAR", 40'h0};
			5'd20: kw_text = {"WHILE", 24'h0};
			5'd21: kw_text = {"WRITE", 24'h0};
			default: kw_text = 64'h0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input logic [4:0] i);
		case (i)
			5'd0: kw_len = 4'd5;   5'd1: kw_len = 4'd7;   5'd2: kw_len = 4'd4;
			5'd3: kw_len = 4'd2;   5'd4: kw_len = 4'd4;   5'd5: kw_len = 4'd3;
			5'd6: kw_len = 4'd5;   5'd7: kw_len = 4'd4;   5'd8: kw_len = 4'd7;
			5'd9: kw_len = 4'd8;   5'd10: kw_len = 4'd2;  5'd11: kw_len = 4'd7;
			5'd12: kw_len = 4'd6;  5'd13: kw_len = 4'd6;  5'd14: kw_len = 4'd4;
			5'd15: kw_len = 4'd4;  5'd16: kw_len = 4'd6;  5'd17: kw_len = 4'd4;
			5'd18: kw_len = 4'd4;  5'd19: kw_len = 4'd3;  5'd20: kw_len = 4'd5;
			5'd21: kw_len = 4'd5;
			default: kw_len = 4'd0;
		endcase
	endfunction

	// One queued word between the scanner and the output side.
	typedef struct packed {
		logic [KindW-1:0]    kind;
		logic [7:0]          ch;
		logic [LineOutW-1:0] line;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/plex_fifo.sv @@
`default_nettype none
module plex_fifo
	import plex_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire res_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output res_t      rd_data
);
	// Four-entry circular queue of result words.
	res_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       do_wr, do_rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'd0, do_wr} - {2'd0, do_rd};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd4) |-> !wr_ready)
		else $error("queue full but accepting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 3'd1))
		else $error("queue count did not grow");
endmodule
`default_nettype wire

@@ rtl/plex_scan.sv @@
`default_nettype none
module plex_scan
	import plex_pkg::*;
#(
	parameter int KEYWORD_CHARS = KeywordCharsDefault,
	parameter int LINE_WIDTH    = LineWidthDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] source_byte,
	input  wire logic       end_of_input,
	output logic            q_valid,
	input  wire logic       q_ready,
	output res_t            q_data
);
	localparam int LenW = $clog2(KEYWORD_CHARS + 2);
	localparam int IdxW = $clog2(KEYWORD_CHARS);
	localparam logic [LenW-1:0] LenMax = LenW'(KEYWORD_CHARS + 1);
	localparam logic [LenW-1:0] LenKeep = LenW'(KEYWORD_CHARS);
	localparam logic [LINE_WIDTH-1:0] LineTop = '1;

	// Front stage: the accepted byte is held while its results, at most two,
	// are formed; pass 0 handles the byte, pass 1 the reprocessed byte.
	logic                  busy_q, pass_q;
	logic [7:0]            c_q;
	logic                  eof_q;
	scan_state_t           st_q;
	logic [7:0]            id_q [KEYWORD_CHARS];
	logic [LenW-1:0]       len_q;
	logic [8:0]            esc_q;
	logic [LINE_WIDTH-1:0] line_q;

	logic        dig, alp, und, spc, nl;
	logic        emit, reproc;
	logic [5:0]  kind;
	logic [7:0]  ch;
	scan_state_t st_n;
	logic        add_id, clr_id, set_esc, clr_esc;
	logic [8:0]  esc_n;
	logic [5:0]  id_kind;
	logic [7:0]  upc;
	logic [12:0] esc_mul;
	logic        step;

	always_comb begin
		dig = !eof_q && c_q >= "0" && c_q <= "9";
		alp = !eof_q && ((c_q >= "A" && c_q <= "Z") || (c_q >= "a" && c_q <= "z"));
		und = !eof_q && c_q == "_";
		spc = c_q == " " || (c_q >= 8'd9 && c_q <= 8'd13);
		nl  = !eof_q && c_q == 8'd10;
		upc = (c_q >= "a" && c_q <= "z") ? c_q - 8'd32 : c_q;
		esc_mul = {4'd0, esc_q} * 13'd10 + {5'd0, c_q[3:0]};
		esc_n = (esc_mul > 13'd256) ? 9'd256 : esc_mul[8:0];
	end

	// Keyword match over the stored identifier; entries beyond the length
	// are not compared.
	always_comb begin
		logic [63:0] t;
		logic        hit;
		id_kind = K_IDENT;
		for (int k = NumKw - 1; k >= 0; k--) begin
			t = kw_text(5'(k));
			hit = (len_q == LenW'(kw_len(5'(k))));
			for (int j = 0; j < 8; j++) begin
				if (j < KEYWORD_CHARS && 4'(j) < kw_len(5'(k))) begin
					hit = hit && (id_q[j] == t[63-8*j -: 8]);
				end
			end
			if (hit) begin
				id_kind = K_KW0 + 6'(k);
			end
		end
	end

	always_comb begin
		emit = 1'b0; reproc = 1'b0; kind = K_ATTR; ch = 8'd0; st_n = st_q;
		add_id = 1'b0; clr_id = 1'b0; set_esc = 1'b0; clr_esc = 1'b0;
		case (st_q)
			S_START: begin
				emit = 1'b1; st_n = S_START;
				if (eof_q) kind = K_EOF;
				else if (spc) emit = 1'b0;
				else if (alp || und) begin
					clr_id = 1'b1; add_id = 1'b1; ch = upc; st_n = S_IDENT;
				end else if (dig) begin ch = c_q; st_n = S_INT; end
				else begin
					case (c_q)
						"{": begin emit = 1'b0; st_n = S_COMMENT; end
						":": begin emit = 1'b0; st_n = S_COLON; end
						"<": begin emit = 1'b0; st_n = S_LESS; end
						">": begin emit = 1'b0; st_n = S_MORE; end
						"'": begin emit = 1'b0; st_n = S_STR; end
						".": kind = K_POINT;
						";": kind = K_SEMI;
						"(": kind = K_LBR;
						")": kind = K_RBR;
						"}": kind = K_RBRACE;
						"+": kind = K_PLUS;
						"-": kind = K_MINUS;
						"*": kind = K_MUL;
						"/": kind = K_DIV;
						"=": kind = K_EQ;
						",": kind = K_COMMA;
						default: kind = K_ERROR;
					endcase
				end
			end
			S_COMMENT: begin
				if (eof_q) begin emit = 1'b1; kind = K_ERROR; st_n = S_START; end
				else if (c_q == "}") st_n = S_START;
			end
			S_COLON: begin
				emit = 1'b1; st_n = S_START;
				if (!eof_q && c_q == "=") kind = K_ASSIGN;
				else begin kind = K_COLON; reproc = 1'b1; end
			end
			S_LESS: begin
				emit = 1'b1; st_n = S_START;
				if (!eof_q && c_q == "=") kind = K_LE;
				else if (!eof_q && c_q == ">") kind = K_NE;
				else begin kind = K_LT; reproc = 1'b1; end
			end
			S_MORE: begin
				emit = 1'b1; st_n = S_START;
				if (!eof_q && c_q == "=") kind = K_GE;
				else begin kind = K_GT; reproc = 1'b1; end
			end
			S_IDENT: begin
				emit = 1'b1;
				if (alp || dig || und) begin add_id = 1'b1; ch = upc; end
				else begin kind = id_kind; reproc = 1'b1; st_n = S_START; end
			end
			S_INT, S_REAL, S_EXP: begin
				emit = 1'b1;
				if (dig) ch = c_q;
				else if (st_q == S_INT && !eof_q && c_q == ".") begin
					ch = c_q; st_n = S_RPOINT;
				end else if (st_q != S_EXP && !eof_q && (c_q == "e" || c_q == "E")) begin
					ch = c_q; st_n = S_ESIGN;
				end else if (alp || und || (st_q != S_INT && !eof_q && c_q == ".")) begin
					kind = K_ERROR; st_n = S_START;
				end else begin
					kind = (st_q == S_INT) ? K_INT : K_REALN;
					reproc = 1'b1; st_n = S_START;
				end
			end
			S_RPOINT, S_ENUM: begin
				emit = 1'b1;
				if (dig) begin ch = c_q; st_n = (st_q == S_RPOINT) ? S_REAL : S_EXP; end
				else begin kind = K_ERROR; st_n = S_START; end
			end
			S_ESIGN: begin
				emit = 1'b1;
				if (dig) begin ch = c_q; st_n = S_EXP; end
				else if (!eof_q && (c_q == "+" || c_q == "-")) begin
					ch = c_q; st_n = S_ENUM;
				end else begin kind = K_ERROR; st_n = S_START; end
			end
			S_STR: begin
				if (eof_q || c_q <= 8'd31) begin
					emit = 1'b1; kind = K_ERROR; st_n = S_START;
				end else if (c_q == "'") st_n = S_QUOTE;
				else begin emit = 1'b1; ch = c_q; end
			end
			S_QUOTE: begin
				if (!eof_q && c_q == "#") begin clr_esc = 1'b1; st_n = S_HASH; end
				else if (!eof_q && c_q == "'") begin emit = 1'b1; ch = c_q; st_n = S_STR; end
				else begin emit = 1'b1; kind = K_STRLIT; reproc = 1'b1; st_n = S_START; end
			end
			S_HASH, S_ESCNUM: begin
				if (dig) begin set_esc = 1'b1; st_n = S_ESCNUM; end
				else if (st_q == S_ESCNUM && !eof_q && c_q == "'" &&
					esc_q >= 9'd1 && esc_q <= 9'd255) begin
					emit = 1'b1; ch = esc_q[7:0]; st_n = S_STR;
				end else begin emit = 1'b1; kind = K_ERROR; st_n = S_START; end
			end
			default: st_n = S_START;
		endcase
	end

	// A pass advances unless its result cannot be queued.
	assign step     = busy_q && (!emit || q_ready);
	assign in_ready = !busy_q || (step && !reproc);
	assign q_valid  = busy_q && emit;

	// Line seen by this pass: pass 1 and non-reprocessed passes see the
	// line after a newline; the pass that hands back its byte sees it before.
	// By pass 1 the count register already holds the line after.
	logic [LINE_WIDTH-1:0] line_inc, line_out;
	assign line_inc = (nl && line_q != LineTop) ? line_q + 1'b1 : line_q;
	assign line_out = (pass_q || reproc) ? line_q : line_inc;
	assign q_data.kind = kind;
	assign q_data.ch   = ch;
	assign q_data.line = LineOutW'(line_out);
	// A reprocessed pass 0 is followed by a result only if pass 1 emits;
	// that is resolved by looking ahead at the start state.
	logic p1_emits;
	always_comb begin
		p1_emits = 1'b1;
		if (!eof_q && (spc || c_q == "{" || c_q == ":" || c_q == "<" ||
			c_q == ">" || c_q == "'")) p1_emits = 1'b0;
	end
	assign q_data.last = !(reproc && !pass_q && p1_emits);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_q   <= source_byte;
			eof_q <= end_of_input;
		end
		if (step && add_id && (clr_id || len_q < LenKeep)) begin
			id_q[clr_id ? '0 : IdxW'(len_q)] <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
			st_q   <= S_START;
			len_q  <= '0;
			esc_q  <= '0;
			line_q <= LINE_WIDTH'(1);
		end else begin
			if (step) begin
				st_q <= st_n;
				if (add_id) begin
					if (clr_id) len_q <= LenW'(1);
					else if (len_q < LenMax) len_q <= len_q + 1'b1;
				end
				if (clr_esc) esc_q <= '0;
				else if (set_esc) esc_q <= esc_n;
				if (reproc && !pass_q) begin
					pass_q <= 1'b1;
					line_q <= line_inc;
				end else begin
					pass_q <= 1'b0;
					if (!pass_q) line_q <= line_inc;
				end
			end
			if (in_valid && in_ready) busy_q <= 1'b1;
			else if (step && !(reproc && !pass_q)) busy_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> busy_q && st_q == S_START)
		else $error("second pass outside start state");
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LenMax)
		else $error("identifier length overflow");
	assert property (@(posedge clk) disable iff (!arst_n) esc_q <= 9'd256)
		else $error("escape overflow");
	assert property (@(posedge clk) disable iff (!arst_n) line_q != '0)
		else $error("line count reached zero");
endmodule
`default_nettype wire

@@ rtl/pascal_like_lexer_unit.sv @@
`default_nettype none
// A byte is registered in the scanner; its results are then registered in the queue.
// Throughput: one byte per cycle unless a result meets a full queue; a byte that ends
// a token is scanned again in a second pass. The single scanning unit sets this rate.
// Output words leave through a four-word queue, so a stall stops the scanner only when the queue is full.
// Reset (arst_n low, asynchronous) puts the scanner in its start state, line one,
// and empties the queue; identifier characters are not cleared.
module pascal_like_lexer_unit
	import plex_pkg::*;
#(
	parameter int KEYWORD_CHARS = KeywordCharsDefault,
	parameter int LINE_WIDTH    = LineWidthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  source_byte,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       item_kind,
	output logic [7:0]       char_value,
	output logic [19:0]      line_number,
	output logic             last_of_run
);
	// The scanner forms one word per cycle; the queue decouples it from
	// the consumer, so a stalled output only stops the scanner when full.
	logic q_valid, q_ready;
	res_t q_data, rd_data;

	plex_scan #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.LINE_WIDTH(LINE_WIDTH)
	) u_scan (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_of_input(end_of_input),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	plex_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(q_valid), .wr_ready(q_ready), .wr_data(q_data),
		.rd_valid(out_valid), .rd_ready(out_ready), .rd_data(rd_data)
	);

	assign item_kind   = rd_data.kind;
	assign char_value  = rd_data.ch;
	assign line_number = rd_data.line;
	assign last_of_run = rd_data.last;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
	import plex_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and the two handshake channels of the scanner.
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] source_byte;
	logic end_of_input;
	logic out_valid;
	logic out_ready;
	logic [5:0] item_kind;
	logic [7:0] char_value;
	logic [19:0] line_number;
	logic last_of_run;

	pascal_like_lexer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.item_kind(item_kind), .char_value(char_value),
		.line_number(line_number), .last_of_run(last_of_run)
	);

	// The expected output word, exactly as it should leave the block.
	typedef struct packed {
		logic [5:0]  kind;
		logic [7:0]  ch;
		logic [19:0] line;
		logic        last;
	} lex_word_t;

	lex_word_t expected_words[$];

	// Our own copy of the scanner state, mirrored from the specification.
	scan_state_t mdl_state;
	logic [7:0]  mdl_ident[8];
	int unsigned mdl_ident_len;
	int unsigned mdl_escape;
	int unsigned mdl_line;

	// Words produced during the current byte, before line numbers are fixed.
	logic [5:0] pend_kind[2];
	logic [7:0] pend_ch[2];
	int pend_n;

	int error_count;
	int idle_cycles;
	int sender_idle_pct;
	int receiver_idle_pct;
	int sent_count;
	bit run_over;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void push_word(input logic [5:0] k, input logic [7:0] c);
		if (pend_n < 2) begin
			pend_kind[pend_n] = k;
			pend_ch[pend_n] = c;
			pend_n++;
		end
	endfunction

	function automatic void close_token(input logic [5:0] k);
		push_word(k, 8'd0);
		mdl_state = S_START;
	endfunction

	function automatic logic [7:0] upper_case(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic void ident_append(input logic [7:0] c);
		if (mdl_ident_len < 8) mdl_ident[mdl_ident_len] = c;
		if (mdl_ident_len < 9) mdl_ident_len++;
		push_word(K_ATTR, c);
	endfunction

	// Keyword lookup on the stored identifier; over-long names never match.
	function automatic logic [5:0] keyword_kind();
		string names[22];
		string s;
		names = '{"BEGIN", "BOOLEAN", "COPY", "DO", "ELSE", "END", "FALSE", "FIND",
			"FORWARD", "FUNCTION", "IF", "INTEGER", "LENGTH", "READLN", "REAL",
			"SORT", "STRING", "THEN", "TRUE", "VAR", "WHILE", "WRITE"};
		s = "";
		if (mdl_ident_len > 8) return K_IDENT;
		for (int i = 0; i < mdl_ident_len; i++) s = {s, string'(mdl_ident[i])};
		for (int i = 0; i < 22; i++)
			if (s == names[i]) return K_KW0 + 6'(i);
		return K_IDENT;
	endfunction

	// One pass of the scanner over a byte; returns 1 if the byte is to be scanned again.
	function automatic bit scan_pass(input logic [7:0] c, input bit eof);
		bit dig, alp, und;
		int unsigned v;
		dig = !eof && c >= "0" && c <= "9";
		alp = !eof && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
		und = !eof && c == "_";
		case (mdl_state)
			S_START: begin
				if (eof) close_token(K_EOF);
				else if (c == " " || (c >= 9 && c <= 13)) ;
				else if (alp || und) begin
					mdl_ident_len = 0;
					ident_append(upper_case(c));
					mdl_state = S_IDENT;
				end else if (dig) begin
					push_word(K_ATTR, c);
					mdl_state = S_INT;
				end else if (c == "{") mdl_state = S_COMMENT;
				else if (c == ":") mdl_state = S_COLON;
				else if (c == "<") mdl_state = S_LESS;
				else if (c == ">") mdl_state = S_MORE;
				else if (c == "'") mdl_state = S_STR;
				else if (c == ".") close_token(K_POINT);
				else if (c == ";") close_token(K_SEMI);
				else if (c == "(") close_token(K_LBR);
				else if (c == ")") close_token(K_RBR);
				else if (c == "}") close_token(K_RBRACE);
				else if (c == "+") close_token(K_PLUS);
				else if (c == "-") close_token(K_MINUS);
				else if (c == "*") close_token(K_MUL);
				else if (c == "/") close_token(K_DIV);
				else if (c == "=") close_token(K_EQ);
				else if (c == ",") close_token(K_COMMA);
				else close_token(K_ERROR);
				return 0;
			end
			S_COMMENT: begin
				if (eof) close_token(K_ERROR);
				else if (c == "}") mdl_state = S_START;
				return 0;
			end
			S_COLON: begin
				if (!eof && c == "=") begin close_token(K_ASSIGN); return 0; end
				close_token(K_COLON);
				return 1;
			end
			S_LESS: begin
				if (!eof && c == "=") begin close_token(K_LE); return 0; end
				if (!eof && c == ">") begin close_token(K_NE); return 0; end
				close_token(K_LT);
				return 1;
			end
			S_MORE: begin
				if (!eof && c == "=") begin close_token(K_GE); return 0; end
				close_token(K_GT);
				return 1;
			end
			S_IDENT: begin
				if (alp || dig || und) begin ident_append(upper_case(c)); return 0; end
				close_token(keyword_kind());
				return 1;
			end
			S_INT: begin
				if (dig) push_word(K_ATTR, c);
				else if (!eof && c == ".") begin
					push_word(K_ATTR, c);
					mdl_state = S_RPOINT;
				end else if (!eof && (c == "e" || c == "E")) begin
					push_word(K_ATTR, c);
					mdl_state = S_ESIGN;
				end else if (alp || und) close_token(K_ERROR);
				else begin close_token(K_INT); return 1; end
				return 0;
			end
			S_RPOINT: begin
				if (dig) begin push_word(K_ATTR, c); mdl_state = S_REAL; end
				else close_token(K_ERROR);
				return 0;
			end
			S_REAL: begin
				if (dig) push_word(K_ATTR, c);
				else if (!eof && (c == "e" || c == "E")) begin
					push_word(K_ATTR, c);
					mdl_state = S_ESIGN;
				end else if (alp || und || (!eof && c == ".")) close_token(K_ERROR);
				else begin close_token(K_REALN); return 1; end
				return 0;
			end
			S_ESIGN: begin
				if (dig) begin push_word(K_ATTR, c); mdl_state = S_EXP; end
				else if (!eof && (c == "+" || c == "-")) begin
					push_word(K_ATTR, c);
					mdl_state = S_ENUM;
				end else close_token(K_ERROR);
				return 0;
			end
			S_ENUM: begin
				if (dig) begin push_word(K_ATTR, c); mdl_state = S_EXP; end
				else close_token(K_ERROR);
				return 0;
			end
			S_EXP: begin
				if (dig) push_word(K_ATTR, c);
				else if (alp || und || (!eof && c == ".")) close_token(K_ERROR);
				else begin close_token(K_REALN); return 1; end
				return 0;
			end
			S_STR: begin
				if (eof || c <= 8'd31) close_token(K_ERROR);
				else if (c == "'") mdl_state = S_QUOTE;
				else push_word(K_ATTR, c);
				return 0;
			end
			S_QUOTE: begin
				if (!eof && c == "#") begin
					mdl_escape = 0;
					mdl_state = S_HASH;
				end else if (!eof && c == "'") begin
					push_word(K_ATTR, c);
					mdl_state = S_STR;
				end else begin close_token(K_STRLIT); return 1; end
				return 0;
			end
			default: begin
				// Escape digits after a hash and the closing quote; the value saturates at 256.
				if (dig) begin
					v = mdl_escape * 10 + (c - "0");
					mdl_escape = v > 256 ? 256 : v;
					mdl_state = S_ESCNUM;
				end else if (mdl_state == S_ESCNUM && !eof && c == "'" &&
						mdl_escape >= 1 && mdl_escape <= 255) begin
					push_word(K_ATTR, 8'(mdl_escape));
					mdl_state = S_STR;
				end else close_token(K_ERROR);
				return 0;
			end
		endcase
	endfunction

	function automatic void bump_line();
		if (mdl_line < 20'hFFFFF) mdl_line++;
	endfunction

	// Predicts the words for one accepted byte and queues them.
	function automatic void predict_words(input logic [7:0] c, input bit eof);
		bit nl;
		int unsigned line_a, line_b;
		int first_n;
		lex_word_t w;
		nl = !eof && c == 8'd10;
		pend_n = 0;
		if (scan_pass(c, eof)) begin
			// A token closed by a newline keeps the old line; what follows gets the new one.
			line_a = mdl_line;
			if (nl) bump_line();
			first_n = pend_n;
			void'(scan_pass(c, eof));
			line_b = mdl_line;
		end else begin
			if (nl) bump_line();
			line_a = mdl_line;
			line_b = mdl_line;
			first_n = pend_n;
		end
		for (int i = 0; i < pend_n; i++) begin
			w.kind = pend_kind[i];
			w.ch = pend_ch[i];
			w.line = 20'(i < first_n ? line_a : line_b);
			w.last = (i == pend_n - 1);
			expected_words.push_back(w);
		end
	endfunction

	// Sends one byte to the scanner, with a random gap before it. Valid stays
	// high between bytes sent back to back.
	task automatic send_byte(input logic [7:0] c, input bit eof);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= c;
		end_of_input <= eof;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_words(c, eof);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// Receiver: random stalls, and every accepted word checked against the oldest expectation.
	always @(negedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		lex_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word, kind", item_kind, -1);
			end else begin
				w = expected_words.pop_front();
				if (item_kind !== w.kind) report_mismatch("item_kind", item_kind, w.kind);
				if (char_value !== w.ch) report_mismatch("char_value", char_value, w.ch);
				if (line_number !== w.line) report_mismatch("line_number", line_number, w.line);
				if (last_of_run !== w.last) report_mismatch("last_of_run", last_of_run, w.last);
			end
		end
	end

	// Watchdog: any long stretch with no word moving on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000 && !run_over) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Directed: every operator, keyword forms, and the corner cases of the scanner.
	task automatic test_directed();
		send_text("begin Write function FUNCTIONS abcdefghij x_1 _ ");
		send_text(":= : <= <> < >= > . ; ( ) } + - * / = , ");
		send_text("12 3.5 7e+2 8.25E-1 9e3 1.x 1a 2e; 2e+; 3.5.1 ");
		send_text("'it''s' 'a'#65'b' 'q'#0' 'q'#300' 'q'#255' 'q'#1'#2 ");
		send_text("{ comment } @ \x80\xff");
		send_byte(8'd10, 1'b0);
		send_text("x");
		send_byte(8'd10, 1'b0);
		send_text("'bad");
		send_byte(8'd10, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_text("{open");
		send_byte(8'h55, 1'b1);
		send_text("abc");
		send_byte(8'h00, 1'b1);
		send_text("'open");
		send_byte(8'hAA, 1'b1);
	endtask

	// Random snippets, mostly well-formed tokens with random content.
	task automatic random_token();
		string kws[8];
		int n;
		kws = '{"begin", "while", "Integer", "readln", "copy", "do", "write", "function"};
		case ($urandom_range(11))
			0: send_text(kws[$urandom_range(7)]);
			1: begin
				n = $urandom_range(1, 11);
				for (int i = 0; i < n; i++)
					send_byte("a" + 8'($urandom_range(25)), 1'b0);
			end
			2: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) send_byte("0" + 8'($urandom_range(9)), 1'b0);
				if ($urandom_range(1)) begin
					send_text(".");
					send_byte("0" + 8'($urandom_range(9)), 1'b0);
				end
				if ($urandom_range(1)) send_text($urandom_range(1) ? "e-1" : "E12");
			end
			3: begin
				send_text("'");
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) send_byte(8'($urandom_range(32, 255)), 1'b0);
				if ($urandom_range(1)) send_text($urandom_range(1) ? "'#97" : "''");
				send_text("'");
			end
			4: send_text("{ x y }");
			5: send_text($urandom_range(1) ? ":=" : "<>");
			6: send_byte(8'd10, 1'b0);
			7: send_byte(8'($urandom), 1'b0);
			8: send_byte(8'($urandom), 1'b1);
			default: send_text(" ");
		endcase
		if ($urandom_range(2) == 0) send_text(" ");
	endtask

	task automatic test_random(input int items);
		int start_count;
		start_count = sent_count;
		while (sent_count - start_count < items) begin
			random_token();
		end
		send_byte(8'h00, 1'b1);
	endtask

	// Advances the line count with a long run of newlines; saturation is not reached.
	task automatic test_many_lines();
		repeat (60) send_byte(8'd10, 1'b0);
		send_text("x ");
		send_byte(8'h00, 1'b1);
	endtask

	initial begin
		error_count = 0;
		idle_cycles = 0;
		sent_count = 0;
		run_over = 0;
		sender_idle_pct = 22;
		receiver_idle_pct = 76;
		in_valid = 1'b0;
		source_byte = 8'h00;
		end_of_input = 1'b0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		mdl_state = S_START;
		for (int i = 0; i < 8; i++) mdl_ident[i] = 8'h00;
		mdl_ident_len = 0;
		mdl_escape = 0;
		mdl_line = 1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		// Hold off until the scanner has emptied its queue.
		wait_drained();
		test_random(370);
		sender_idle_pct = 76;
		receiver_idle_pct = 22;
		test_random(370);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random(320);
		test_many_lines();

		wait_drained();
		repeat (20) @(negedge clk);
		run_over = 1;
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/plex_pkg.sv
rtl/plex_fifo.sv
rtl/plex_scan.sv
rtl/pascal_like_lexer_unit.sv
verif/tb.sv
